### rtl/bvm_pkg.sv
// ----------------------------------------------------------------------------
// bvm_pkg
// shared constants, command codes and font glyphs of the bytecode vm core
// ----------------------------------------------------------------------------
package bvm_pkg;

    localparam int C_MEM_DEPTH     = 4096;
    localparam int C_ADDR_W        = $clog2(C_MEM_DEPTH);
    localparam int C_STACK_DEPTH   = 16;
    localparam int C_SCREEN_WIDTH  = 64;
    localparam int C_SCREEN_HEIGHT = 32;
    localparam int C_ROW_W         = $clog2(C_SCREEN_HEIGHT);
    localparam int C_COL_W         = $clog2(C_SCREEN_WIDTH);
    localparam int C_PROGRAM_START = 512;
    localparam int C_FONT_BASE     = 80;
    localparam int C_FONT_BYTES    = 80;
    localparam int C_FONT_IDX_W    = $clog2(C_FONT_BYTES);

    localparam logic [15:0] C_SEED_RESET = 16'd44257;
    localparam logic [15:0] C_LFSR_TAPS  = 16'hB400;

    // commands
    localparam logic [1:0] C_CMD_LOAD = 2'd0;
    localparam logic [1:0] C_CMD_EXEC = 2'd1;
    localparam logic [1:0] C_CMD_ROW  = 2'd2;

    // fault codes
    localparam logic [1:0] C_FLT_NONE  = 2'd0;
    localparam logic [1:0] C_FLT_OPC   = 2'd1;
    localparam logic [1:0] C_FLT_OVER  = 2'd2;
    localparam logic [1:0] C_FLT_UNDER = 2'd3;

    // special opcodes and sub-codes
    localparam logic [15:0] C_OP_CLS   = 16'h00E0;
    localparam logic [15:0] C_OP_RET   = 16'h00EE;
    localparam logic [7:0]  C_KEY_DOWN = 8'h9E;
    localparam logic [7:0]  C_KEY_UP   = 8'hA1;
    localparam logic [7:0]  C_F_GETDLY = 8'h07;
    localparam logic [7:0]  C_F_WAITK  = 8'h0A;
    localparam logic [7:0]  C_F_SETDLY = 8'h15;
    localparam logic [7:0]  C_F_SETSND = 8'h18;
    localparam logic [7:0]  C_F_ADDI   = 8'h1E;
    localparam logic [7:0]  C_F_FONT   = 8'h29;
    localparam logic [7:0]  C_F_BCD    = 8'h33;
    localparam logic [7:0]  C_F_STORE  = 8'h55;
    localparam logic [7:0]  C_F_LOAD   = 8'h65;

    localparam logic [7:0] C_FONT [0:C_FONT_BYTES-1] = '{
        8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
        8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
        8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
        8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
        8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
    };

endpackage

### rtl/bvm_if.sv
// ----------------------------------------------------------------------------
// bvm_if
// item channels of the bytecode vm core: command in, result out, seed write
// ----------------------------------------------------------------------------
interface bvm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [11:0] address;
    logic [7:0]  data;
    logic [15:0] keys_down;
    logic [4:0]  row;

    modport source (output valid, command, address, data, keys_down, row, input ready);
    modport sink   (input valid, command, address, data, keys_down, row, output ready);
endinterface

interface bvm_out_if;
    logic        valid;
    logic        ready;
    logic [11:0] program_counter;
    logic [15:0] instruction;
    logic [63:0] row_pixels;
    logic        waiting_key;
    logic [1:0]  fault;
    logic        sound_on;
    logic        screen_changed;

    modport source (output valid, program_counter, instruction, row_pixels, waiting_key,
                    fault, sound_on, screen_changed, input ready);
    modport sink   (input valid, program_counter, instruction, row_pixels, waiting_key,
                    fault, sound_on, screen_changed, output ready);
endinterface

interface bvm_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

### rtl/bvm_ram.sv
// ----------------------------------------------------------------------------
// bvm_ram
// generic ram, one write port, one read port, registered read data
// ----------------------------------------------------------------------------
module bvm_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr,
    output logic [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [0:D-1];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/bytecode_vm_execute_core.sv
// ----------------------------------------------------------------------------
// bytecode_vm_execute_core
// eight-bit vm core: memory, registers, stack and screen in rams, sequencer
// ----------------------------------------------------------------------------
// channel   dir  handshake              payload
// i_in      in   valid/ready            command, address, data, keys_down, row
// o_out     out  valid/ready            pc, instruction, row pixels, status
// i_cfg     in   valid/ready (always 1) random seed
//
// a load or no-op goes straight to the result, a row read reads the screen, an
// execute fetches the opcode, reads registers and may walk draw (per row), bcd
// (per digit) or block copy (per register), each bound by the one read and one
// write port of memory and register file; after reset a clearing pass over
// all 4096 bytes loads the font and zeroes memory and registers, taking no
// item; the next item is taken while a result waits in the output register
// ----------------------------------------------------------------------------
module bytecode_vm_execute_core #(
    parameter int STACK_DEPTH = bvm_pkg::C_STACK_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bvm_in_if.sink    i_in,
    bvm_out_if.source o_out,
    bvm_cfg_if.sink   i_cfg
);
    import bvm_pkg::*;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int SLW = $clog2(STACK_DEPTH + 1);

    // sequencer codes
    localparam logic [4:0] S_INIT = 5'd0;
    localparam logic [4:0] S_IDLE = 5'd1;
    localparam logic [4:0] S_ROW  = 5'd2;
    localparam logic [4:0] S_FHI  = 5'd3;
    localparam logic [4:0] S_FLO  = 5'd4;
    localparam logic [4:0] S_RDX  = 5'd5;
    localparam logic [4:0] S_RDY  = 5'd6;
    localparam logic [4:0] S_EXEC = 5'd7;
    localparam logic [4:0] S_WRF  = 5'd8;
    localparam logic [4:0] S_DRA  = 5'd9;
    localparam logic [4:0] S_DRB  = 5'd10;
    localparam logic [4:0] S_DRC  = 5'd11;
    localparam logic [4:0] S_BCD  = 5'd12;
    localparam logic [4:0] S_STA  = 5'd13;
    localparam logic [4:0] S_STB  = 5'd14;
    localparam logic [4:0] S_LDA  = 5'd15;
    localparam logic [4:0] S_LDB  = 5'd16;
    localparam logic [4:0] S_FIN  = 5'd17;

    // control state
    logic [4:0]           r_state, n_state;
    logic [C_ADDR_W-1:0]  r_cnt, n_cnt;
    logic [11:0]          r_pc, n_pc;
    logic [15:0]          r_index, n_index;
    logic [7:0]           r_delay, n_delay;
    logic [7:0]           r_sound, n_sound;
    logic [SLW-1:0]       r_level, n_level;
    logic [15:0]          r_lfsr, n_lfsr;
    logic [C_SCREEN_HEIGHT-1:0] r_scr_valid, n_scr_valid;
    logic                 r_out_valid, n_out_valid;

    // item working registers
    logic [1:0]  r_cmd, n_cmd;
    logic [15:0] r_keys, n_keys;
    logic [4:0]  r_row, n_row;
    logic [7:0]  r_hi, n_hi;
    logic [15:0] r_op, n_op;
    logic [7:0]  r_vx, n_vx;
    logic [7:0]  r_vy, n_vy;
    logic [7:0]  r_flag, n_flag;
    logic [7:0]  r_sprite, n_sprite;
    logic        r_hit, n_hit;
    logic        r_wait, n_wait;
    logic [1:0]  r_fault, n_fault;
    logic        r_changed, n_changed;
    logic [63:0] r_pix, n_pix;

    // output register
    logic [11:0] r_o_pc, n_o_pc;
    logic [15:0] r_o_op, n_o_op;
    logic [63:0] r_o_pix, n_o_pix;
    logic        r_o_wait, n_o_wait;
    logic [1:0]  r_o_fault, n_o_fault;
    logic        r_o_sound, n_o_sound;
    logic        r_o_changed, n_o_changed;

    // ram ports
    logic                mem_we;
    logic [C_ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [7:0]          mem_wdata, mem_rdata;
    logic                v_we;
    logic [3:0]          v_waddr, v_raddr;
    logic [7:0]          v_wdata, v_rdata;
    logic                stk_we;
    logic [SAW-1:0]      stk_waddr, stk_raddr;
    logic [11:0]         stk_wdata, stk_rdata;
    logic                scr_we;
    logic [C_ROW_W-1:0]  scr_waddr, scr_raddr;
    logic [63:0]         scr_wdata, scr_rdata;

    bvm_ram #(.W(8), .D(C_MEM_DEPTH)) u_mem (
        .i_clk(i_clk), .i_we(mem_we), .i_waddr(mem_waddr), .i_wdata(mem_wdata),
        .i_raddr(mem_raddr), .o_rdata(mem_rdata)
    );
    bvm_ram #(.W(8), .D(16)) u_vreg (
        .i_clk(i_clk), .i_we(v_we), .i_waddr(v_waddr), .i_wdata(v_wdata),
        .i_raddr(v_raddr), .o_rdata(v_rdata)
    );
    bvm_ram #(.W(12), .D(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(stk_we), .i_waddr(stk_waddr), .i_wdata(stk_wdata),
        .i_raddr(stk_raddr), .o_rdata(stk_rdata)
    );
    bvm_ram #(.W(C_SCREEN_WIDTH), .D(C_SCREEN_HEIGHT)) u_screen (
        .i_clk(i_clk), .i_we(scr_we), .i_waddr(scr_waddr), .i_wdata(scr_wdata),
        .i_raddr(scr_raddr), .o_rdata(scr_rdata)
    );

    // opcode fields
    logic [3:0]  op_x, op_y, op_n;
    logic [7:0]  op_nn;
    logic [11:0] op_nnn;
    logic [11:0] pc_next, pc_skip;
    assign op_x    = r_op[11:8];
    assign op_y    = r_op[7:4];
    assign op_n    = r_op[3:0];
    assign op_nn   = r_op[7:0];
    assign op_nnn  = r_op[11:0];
    assign pc_next = r_pc + 12'd2;
    assign pc_skip = r_pc + 12'd4;

    // index plus loop count, wrapped to the memory
    logic [C_ADDR_W-1:0] idx_addr;
    assign idx_addr = r_index[C_ADDR_W-1:0] + r_cnt;

    // bcd digits by compares and a reciprocal multiply
    logic [7:0]  bcd_h;
    logic [6:0]  bcd_rem;
    logic [14:0] bcd_mul;
    logic [3:0]  bcd_t;
    logic [3:0]  bcd_o;
    always_comb begin
        if (r_vx >= 8'd200) begin
            bcd_h = 8'd2;
        end else if (r_vx >= 8'd100) begin
            bcd_h = 8'd1;
        end else begin
            bcd_h = 8'd0;
        end
        bcd_rem = 7'(r_vx - 8'(bcd_h * 8'd100));
        bcd_mul = 15'(bcd_rem) * 15'd205;
        bcd_t   = bcd_mul[14:11];
        bcd_o   = 4'(bcd_rem - 7'(bcd_t * 4'd10));
    end

    // sprite row placed at the column, wrapping
    logic [127:0] spr_dbl;
    logic [63:0]  spr_bits;
    logic [63:0]  scr_old;
    logic [C_ROW_W-1:0] draw_row;
    assign spr_dbl  = {r_sprite, 56'd0, r_sprite, 56'd0} >> r_vx[C_COL_W-1:0];
    assign spr_bits = spr_dbl[63:0];
    assign draw_row = r_vy[C_ROW_W-1:0] + C_ROW_W'(r_cnt);
    assign scr_old  = r_scr_valid[draw_row] ? scr_rdata : 64'd0;

    // lowest pressed key
    logic [3:0] key_low;
    always_comb begin
        key_low = 4'd0;
        for (int k = 15; k >= 0; k--) begin
            if (r_keys[k]) begin
                key_low = 4'(k);
            end
        end
    end

    // font table offset of the clearing pass
    logic [C_ADDR_W-1:0] font_off;
    assign font_off = r_cnt - C_ADDR_W'(C_FONT_BASE);

    logic [8:0]  alu_sum;
    logic [15:0] lfsr_step;
    logic [7:0]  sound_dec;
    assign alu_sum   = {1'b0, r_vx} + {1'b0, r_vy};
    assign lfsr_step = (r_lfsr >> 1) ^ (r_lfsr[0] ? C_LFSR_TAPS : 16'd0);
    assign sound_dec = r_sound - ((r_sound != 8'd0) ? 8'd1 : 8'd0);

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_pc        = r_pc;
        n_index     = r_index;
        n_delay     = r_delay;
        n_sound     = r_sound;
        n_level     = r_level;
        n_lfsr      = r_lfsr;
        n_scr_valid = r_scr_valid;
        n_out_valid = r_out_valid;
        n_cmd       = r_cmd;
        n_keys      = r_keys;
        n_row       = r_row;
        n_hi        = r_hi;
        n_op        = r_op;
        n_vx        = r_vx;
        n_vy        = r_vy;
        n_flag      = r_flag;
        n_sprite    = r_sprite;
        n_hit       = r_hit;
        n_wait      = r_wait;
        n_fault     = r_fault;
        n_changed   = r_changed;
        n_pix       = r_pix;
        n_o_pc      = r_o_pc;
        n_o_op      = r_o_op;
        n_o_pix     = r_o_pix;
        n_o_wait    = r_o_wait;
        n_o_fault   = r_o_fault;
        n_o_sound   = r_o_sound;
        n_o_changed = r_o_changed;

        mem_we    = 1'b0;
        mem_waddr = idx_addr;
        mem_wdata = 8'd0;
        mem_raddr = idx_addr;
        v_we      = 1'b0;
        v_waddr   = op_x;
        v_wdata   = 8'd0;
        v_raddr   = 4'd0;
        stk_we    = 1'b0;
        stk_waddr = SAW'(r_level);
        stk_wdata = pc_next;
        stk_raddr = SAW'(r_level - SLW'(1));
        scr_we    = 1'b0;
        scr_waddr = draw_row;
        scr_wdata = scr_old ^ spr_bits;
        scr_raddr = draw_row;

        // result taken
        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_INIT: begin
                // font at its base, zero elsewhere, registers zero
                mem_we    = 1'b1;
                mem_waddr = r_cnt;
                mem_wdata = (font_off < C_ADDR_W'(C_FONT_BYTES)) ?
                            C_FONT[C_FONT_IDX_W'(font_off)] : 8'd0;
                v_we      = 1'b1;
                v_waddr   = r_cnt[3:0];
                n_cnt     = r_cnt + C_ADDR_W'(1);
                if (r_cnt == C_ADDR_W'(C_MEM_DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in.valid) begin
                    n_cmd     = i_in.command;
                    n_keys    = i_in.keys_down;
                    n_row     = i_in.row;
                    n_op      = 16'd0;
                    n_pix     = 64'd0;
                    n_wait    = 1'b0;
                    n_fault   = C_FLT_NONE;
                    n_changed = 1'b0;
                    n_state   = S_FIN;
                    case (i_in.command)
                        C_CMD_LOAD: begin
                            mem_we    = 1'b1;
                            mem_waddr = i_in.address;
                            mem_wdata = i_in.data;
                        end
                        C_CMD_EXEC: begin
                            mem_raddr = r_pc;
                            n_state   = S_FHI;
                        end
                        C_CMD_ROW: begin
                            scr_raddr = i_in.row;
                            n_state   = S_ROW;
                        end
                        default: begin
                            n_state = S_FIN;
                        end
                    endcase
                end
            end
            S_ROW: begin
                n_pix   = r_scr_valid[r_row] ? scr_rdata : 64'd0;
                n_state = S_FIN;
            end
            S_FHI: begin
                n_hi      = mem_rdata;
                mem_raddr = r_pc + 12'd1;
                n_state   = S_FLO;
            end
            S_FLO: begin
                n_op    = {r_hi, mem_rdata};
                v_raddr = r_hi[3:0];
                n_state = S_RDX;
            end
            S_RDX: begin
                n_vx    = v_rdata;
                v_raddr = op_y;
                n_state = S_RDY;
            end
            S_RDY: begin
                // v0 and top of stack are read for the jump and return
                n_vy    = v_rdata;
                v_raddr = 4'd0;
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_FIN;
                n_cnt   = '0;
                case (r_op[15:12])
                    4'h0: begin
                        if (r_op == C_OP_CLS) begin
                            n_scr_valid = '0;
                            n_changed   = 1'b1;
                            n_pc        = pc_next;
                        end else if (r_op == C_OP_RET) begin
                            if (r_level == '0) begin
                                n_fault = C_FLT_UNDER;
                            end else begin
                                n_level = r_level - SLW'(1);
                                n_pc    = stk_rdata;
                            end
                        end else begin
                            n_fault = C_FLT_OPC;
                        end
                    end
                    4'h1: n_pc = op_nnn;
                    4'h2: begin
                        if (r_level >= SLW'(STACK_DEPTH)) begin
                            n_fault = C_FLT_OVER;
                        end else begin
                            stk_we  = 1'b1;
                            n_level = r_level + SLW'(1);
                            n_pc    = op_nnn;
                        end
                    end
                    4'h3: n_pc = (r_vx == op_nn) ? pc_skip : pc_next;
                    4'h4: n_pc = (r_vx != op_nn) ? pc_skip : pc_next;
                    4'h5: n_pc = (r_vx == r_vy) ? pc_skip : pc_next;
                    4'h9: n_pc = (r_vx != r_vy) ? pc_skip : pc_next;
                    4'h6: begin
                        v_we    = 1'b1;
                        v_wdata = op_nn;
                        n_pc    = pc_next;
                    end
                    4'h7: begin
                        v_we    = 1'b1;
                        v_wdata = r_vx + op_nn;
                        n_pc    = pc_next;
                    end
                    4'h8: begin
                        n_pc = pc_next;
                        v_we = 1'b1;
                        case (op_n)
                            4'h0: v_wdata = r_vy;
                            4'h1: v_wdata = r_vx | r_vy;
                            4'h2: v_wdata = r_vx & r_vy;
                            4'h3: v_wdata = r_vx ^ r_vy;
                            4'h4: begin
                                // result first, carry to vf next cycle
                                v_wdata = alu_sum[7:0];
                                n_flag  = {7'd0, alu_sum[8]};
                                n_state = S_WRF;
                            end
                            4'h5: begin
                                v_wdata = r_vx - r_vy;
                                n_flag  = {7'd0, (r_vx >= r_vy)};
                                n_state = S_WRF;
                            end
                            4'h6: begin
                                v_wdata = r_vx >> 1;
                                n_flag  = {7'd0, r_vx[0]};
                                n_state = S_WRF;
                            end
                            4'h7: begin
                                v_wdata = r_vy - r_vx;
                                n_flag  = {7'd0, (r_vy >= r_vx)};
                                n_state = S_WRF;
                            end
                            4'hE: begin
                                v_wdata = r_vx << 1;
                                n_flag  = {7'd0, r_vx[7]};
                                n_state = S_WRF;
                            end
                            default: begin
                                v_we    = 1'b0;
                                n_fault = C_FLT_OPC;
                                n_pc    = r_pc;
                            end
                        endcase
                    end
                    4'hA: begin
                        n_index = {4'd0, op_nnn};
                        n_pc    = pc_next;
                    end
                    4'hB: n_pc = op_nnn + {4'd0, v_rdata};
                    4'hC: begin
                        n_lfsr  = lfsr_step;
                        v_we    = 1'b1;
                        v_wdata = lfsr_step[7:0] & op_nn;
                        n_pc    = pc_next;
                    end
                    4'hD: begin
                        n_changed = 1'b1;
                        n_hit     = 1'b0;
                        n_pc      = pc_next;
                        if (op_n == 4'd0) begin
                            n_flag  = 8'd0;
                            n_state = S_WRF;
                        end else begin
                            n_state = S_DRA;
                        end
                    end
                    4'hE: begin
                        if (op_nn == C_KEY_DOWN) begin
                            n_pc = r_keys[r_vx[3:0]] ? pc_skip : pc_next;
                        end else if (op_nn == C_KEY_UP) begin
                            n_pc = r_keys[r_vx[3:0]] ? pc_next : pc_skip;
                        end else begin
                            n_fault = C_FLT_OPC;
                        end
                    end
                    default: begin
                        n_pc = pc_next;
                        case (op_nn)
                            C_F_GETDLY: begin
                                v_we    = 1'b1;
                                v_wdata = r_delay;
                            end
                            C_F_WAITK: begin
                                if (r_keys == 16'd0) begin
                                    n_wait = 1'b1;
                                    n_pc   = r_pc;
                                end else begin
                                    v_we    = 1'b1;
                                    v_wdata = {4'd0, key_low};
                                end
                            end
                            C_F_SETDLY: n_delay = r_vx;
                            C_F_SETSND: n_sound = r_vx;
                            C_F_ADDI:   n_index = r_index + {8'd0, r_vx};
                            C_F_FONT: begin
                                n_index = 16'(C_FONT_BASE) + 16'(r_vx[3:0]) * 16'd5;
                            end
                            C_F_BCD:   n_state = S_BCD;
                            C_F_STORE: n_state = S_STA;
                            C_F_LOAD:  n_state = S_LDA;
                            default: begin
                                n_fault = C_FLT_OPC;
                                n_pc    = r_pc;
                            end
                        endcase
                    end
                endcase
            end
            S_WRF: begin
                v_we    = 1'b1;
                v_waddr = 4'hF;
                v_wdata = r_flag;
                n_state = S_FIN;
            end
            S_DRA: begin
                // sprite byte at index plus row count
                n_state = S_DRB;
            end
            S_DRB: begin
                n_sprite = mem_rdata;
                n_state  = S_DRC;
            end
            S_DRC: begin
                // xor the row in, note any lit pixel that goes dark
                scr_we                = 1'b1;
                n_scr_valid[draw_row] = 1'b1;
                n_hit                 = r_hit | (|(scr_old & spr_bits));
                n_cnt                 = r_cnt + C_ADDR_W'(1);
                if (r_cnt[3:0] + 4'd1 == op_n) begin
                    n_flag  = {7'd0, n_hit};
                    n_state = S_WRF;
                end else begin
                    n_state = S_DRA;
                end
            end
            S_BCD: begin
                mem_we = 1'b1;
                case (r_cnt[1:0])
                    2'd0:    mem_wdata = bcd_h;
                    2'd1:    mem_wdata = {4'd0, bcd_t};
                    default: mem_wdata = {4'd0, bcd_o};
                endcase
                n_cnt = r_cnt + C_ADDR_W'(1);
                if (r_cnt[1:0] == 2'd2) begin
                    n_state = S_FIN;
                end
            end
            S_STA: begin
                v_raddr = r_cnt[3:0];
                n_state = S_STB;
            end
            S_STB: begin
                mem_we    = 1'b1;
                mem_wdata = v_rdata;
                n_cnt     = r_cnt + C_ADDR_W'(1);
                n_state   = (r_cnt[3:0] == op_x) ? S_FIN : S_STA;
            end
            S_LDA: begin
                n_state = S_LDB;
            end
            S_LDB: begin
                v_we    = 1'b1;
                v_waddr = r_cnt[3:0];
                v_wdata = mem_rdata;
                n_cnt   = r_cnt + C_ADDR_W'(1);
                n_state = (r_cnt[3:0] == op_x) ? S_FIN : S_LDA;
            end
            S_FIN: begin
                // load the output register once it is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_pc      = r_pc;
                    n_o_op      = r_op;
                    n_o_pix     = r_pix;
                    n_o_wait    = r_wait;
                    n_o_fault   = r_fault;
                    n_o_changed = r_changed;
                    n_o_sound   = (r_sound != 8'd0);
                    if (r_cmd == C_CMD_EXEC) begin
                        n_delay   = r_delay - ((r_delay != 8'd0) ? 8'd1 : 8'd0);
                        n_sound   = sound_dec;
                        n_o_sound = (sound_dec != 8'd0);
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // seed write reloads the lfsr
        if (i_cfg.valid) begin
            n_lfsr = i_cfg.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_INIT;
            r_cnt       <= '0;
            r_pc        <= 12'(C_PROGRAM_START);
            r_index     <= 16'd0;
            r_delay     <= 8'd0;
            r_sound     <= 8'd0;
            r_level     <= '0;
            r_lfsr      <= C_SEED_RESET;
            r_scr_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_pc        <= n_pc;
            r_index     <= n_index;
            r_delay     <= n_delay;
            r_sound     <= n_sound;
            r_level     <= n_level;
            r_lfsr      <= n_lfsr;
            r_scr_valid <= n_scr_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd       <= n_cmd;
        r_keys      <= n_keys;
        r_row       <= n_row;
        r_hi        <= n_hi;
        r_op        <= n_op;
        r_vx        <= n_vx;
        r_vy        <= n_vy;
        r_flag      <= n_flag;
        r_sprite    <= n_sprite;
        r_hit       <= n_hit;
        r_wait      <= n_wait;
        r_fault     <= n_fault;
        r_changed   <= n_changed;
        r_pix       <= n_pix;
        r_o_pc      <= n_o_pc;
        r_o_op      <= n_o_op;
        r_o_pix     <= n_o_pix;
        r_o_wait    <= n_o_wait;
        r_o_fault   <= n_o_fault;
        r_o_sound   <= n_o_sound;
        r_o_changed <= n_o_changed;
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.program_counter = r_o_pc;
    assign o_out.instruction     = r_o_op;
    assign o_out.row_pixels      = r_o_pix;
    assign o_out.waiting_key     = r_o_wait;
    assign o_out.fault           = r_o_fault;
    assign o_out.sound_on        = r_o_sound;
    assign o_out.screen_changed  = r_o_changed;

    // stack never holds more than its depth
    a_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_level <= SLW'(STACK_DEPTH))
        else $error("stack level beyond depth");

    // a faulting step leaves the pc where it was
    a_fault_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC && n_fault != C_FLT_NONE) |=> (r_pc == $past(r_pc)))
        else $error("pc moved on a fault");

    // a screen change comes only from an executed opcode
    a_changed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.screen_changed) |-> (o_out.instruction != 16'd0))
        else $error("screen change without opcode");

    // nothing is taken during the clearing pass
    a_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INIT) |-> !i_in.ready)
        else $error("item taken during clearing pass");
endmodule
